### rtl/cbe_pkg.sv
// Shared types, constants and helper functions of the cubic Bezier easing solver.
`default_nettype none
package cbe_pkg;
  localparam int W = 36;
  localparam int TW = 32;
  localparam int DW = 17;
  localparam int CFG_IDX_W = 1;

  typedef logic signed [W-1:0] word_t;

  localparam logic [DW-1:0] ONE_Q16 = 17'h10000;
  localparam word_t ONE_Q30 = 36'sh0_4000_0000;
  localparam word_t MIN_SLOPE = 36'sd1073742;
  localparam word_t PREC = 36'sd107;
  localparam word_t DIV_SAT = 36'sh1_0000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_FIRST  = 1'b0,
    REG_X_SECOND = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic  mul_go;
    logic  div_go;
    word_t a;
    word_t b;
  } arith_req_t;

  typedef struct packed {
    logic  done;
    word_t res;
  } arith_rsp_t;

  function automatic logic [DW-1:0] sat_q16(logic [DW-1:0] v);
    return (v > ONE_Q16) ? ONE_Q16 : v;
  endfunction

  function automatic word_t clamp_unit(word_t t);
    word_t r;
    r = t;
    if (t < 0) r = '0;
    else if (t > ONE_Q30) r = ONE_Q30;
    return r;
  endfunction
endpackage
`default_nettype wire

### rtl/cbe_in_if.sv
// Input channel: progress values with valid/ready.
`default_nettype none
interface cbe_in_if;
  logic valid;
  logic ready;
  logic [16:0] progress;
  modport source (output valid, output progress, input ready);
  modport sink (input valid, input progress, output ready);
endinterface
`default_nettype wire

### rtl/cbe_out_if.sv
// Output channel: solved curve parameters with valid/ready.
`default_nettype none
interface cbe_out_if;
  logic valid;
  logic ready;
  logic [16:0] curve_param;
  modport source (output valid, output curve_param, input ready);
  modport sink (input valid, input curve_param, output ready);
endinterface
`default_nettype wire

### rtl/cbe_front.sv
// Front end: accept and saturate progress values into a two-entry queue.
`default_nettype none
module cbe_front (
  input  logic          clk,
  input  logic          rst,
  cbe_in_if.sink        in_ch,
  output logic          item_valid,
  input  logic          item_ready,
  output cbe_pkg::word_t item_x
);
  logic [cbe_pkg::DW-1:0] q [2];
  logic wp;
  logic rp;
  logic [1:0] cnt;
  logic push;
  logic pop;

  assign in_ch.ready = (cnt != 2'd2);
  assign push = in_ch.valid && in_ch.ready;
  assign item_valid = (cnt != 2'd0);
  assign pop = item_valid && item_ready;
  assign item_x = cbe_pkg::word_t'(cbe_pkg::W'({q[rp], 14'b0}));

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= cbe_pkg::sat_q16(in_ch.progress);
    end
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      if (push && !pop) cnt <= cnt + 2'd1;
      else if (pop && !push) cnt <= cnt - 2'd1;
    end
  end
endmodule
`default_nettype wire

### rtl/cbe_arith.sv
// Shared multi-cycle unit: rounded Q6.30 multiply and truncating, saturating Q6.30 divide.
`default_nettype none
module cbe_arith (
  input  logic                clk,
  input  logic                rst,
  input  cbe_pkg::arith_req_t req,
  output cbe_pkg::arith_rsp_t rsp
);
  localparam int W = cbe_pkg::W;

  typedef enum logic [2:0] {A_IDLE, A_M1, A_M2, A_M3, A_DIV} st_t;

  st_t st;
  logic neg;
  logic [W-1:0] pm;
  logic [30:0] q;
  logic [66:0] acc;
  logic [66:0] rem;
  logic [66:0] dsh;
  logic [31:0] quo;
  logic [4:0] cnt;
  logic [17:0] pm_sel;
  logic [48:0] pp;
  logic [66:0] rnd;
  logic [W-1:0] rmag;
  logic [31:0] qn;
  logic [W-1:0] na;
  logic [W-1:0] nd;

  function automatic logic [W-1:0] mag(cbe_pkg::word_t v);
    return v[W-1] ? W'(-v) : W'(v);
  endfunction

  assign na = mag(req.a);
  assign nd = mag(req.b);
  assign pm_sel = (st == A_M1) ? pm[17:0] : pm[35:18];
  assign pp = pm_sel * q;
  assign rnd = acc + 67'(64'd1 << 29);
  assign rmag = W'(rnd >> 30);
  assign qn = (rem >= dsh) ? {quo[30:0], 1'b1} : {quo[30:0], 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= A_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      unique case (st)
        A_IDLE: begin
          if (req.mul_go) begin
            pm <= na;
            q <= nd[30:0];
            neg <= req.a[W-1] ^ req.b[W-1];
            acc <= '0;
            st <= A_M1;
          end else if (req.div_go) begin
            neg <= req.a[W-1] ^ req.b[W-1];
            if ({2'b00, na} >= {nd, 2'b00}) begin
              rsp.res <= (req.a[W-1] ^ req.b[W-1]) ? -cbe_pkg::DIV_SAT : cbe_pkg::DIV_SAT;
              rsp.done <= 1'b1;
            end else begin
              rem <= 67'(na) << 30;
              dsh <= 67'(nd) << 31;
              quo <= '0;
              cnt <= '0;
              st <= A_DIV;
            end
          end
        end
        A_M1: begin
          acc <= 67'(pp);
          st <= A_M2;
        end
        A_M2: begin
          acc <= acc + (67'(pp) << 18);
          st <= A_M3;
        end
        A_M3: begin
          rsp.res <= neg ? cbe_pkg::word_t'(-rmag) : cbe_pkg::word_t'(rmag);
          rsp.done <= 1'b1;
          st <= A_IDLE;
        end
        A_DIV: begin
          if (rem >= dsh) rem <= rem - dsh;
          quo <= qn;
          dsh <= dsh >> 1;
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            rsp.res <= neg ? -cbe_pkg::word_t'(W'(qn)) : cbe_pkg::word_t'(W'(qn));
            rsp.done <= 1'b1;
            st <= A_IDLE;
          end
        end
        default: st <= A_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### rtl/cbe_back.sv
// Back end: sample table, solve sequencer and output register.
`default_nettype none
module cbe_back #(
  parameter int SPLINE_POINTS = 11,
  parameter int NEWTON_STEPS = 4,
  parameter int BISECT_STEPS = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [cbe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cbe_pkg::DW-1:0]        cfg_data,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  cbe_pkg::word_t                item_x,
  cbe_out_if.source                     out_ch,
  output cbe_pkg::arith_req_t           areq,
  input  cbe_pkg::arith_rsp_t           arsp
);
  localparam int W = cbe_pkg::W;
  localparam int TW = cbe_pkg::TW;
  localparam int IW = $clog2(SPLINE_POINTS);
  localparam int SEGS = SPLINE_POINTS - 1;
  localparam int HALF = SEGS / 2;
  localparam int NW = (NEWTON_STEPS > 0) ? $clog2(NEWTON_STEPS + 1) : 1;
  localparam int BW = (BISECT_STEPS > 1) ? $clog2(BISECT_STEPS) : 1;

  typedef enum logic [4:0] {
    S_IDLE, S_FILL_INIT, S_FILL_WR,
    S_EX_A, S_EX_B, S_EX_C, S_ES_A, S_ES_B, S_ES_C,
    S_SCAN_RD, S_SCAN_CMP, S_LD0, S_LD1, S_LD2,
    S_DIST, S_DDIV, S_GUESS, S_SLOPE0,
    S_NT_CHK, S_NT_X, S_NT_DIV, S_BS_MID, S_BS_CHK, S_FINISH
  } state_t;

  state_t state;
  state_t ret;
  logic pend;
  logic issued;
  logic [cbe_pkg::DW-1:0] x1;
  logic [cbe_pkg::DW-1:0] x2;
  cbe_pkg::word_t coef_a, coef_b, coef_c;
  cbe_pkg::word_t xin, tt, xv, sv, t2, s1, v0, v1, lo, hi, frac;
  logic [IW-1:0] fi;
  logic [IW-1:0] cur;
  logic [IW-1:0] rd_addr;
  logic [NW-1:0] nk;
  logic [BW-1:0] bi;
  logic signed [TW-1:0] mem [SPLINE_POINTS];
  logic signed [TW-1:0] rdata;
  cbe_pkg::word_t rdv;
  cbe_pkg::word_t tpos [SPLINE_POINTS];
  cbe_pkg::word_t num, den, cx, x1q, x2q, tfin;
  logic [cbe_pkg::DW-1:0] ovalue;
  logic ovalid;
  logic arith_state;

  for (genvar g = 0; g < SPLINE_POINTS; g++) begin : g_tpos
    assign tpos[g] = cbe_pkg::word_t'(((64'(g) << 30) + 64'(HALF)) / SEGS);
  end

  assign rdv = W'(rdata);
  assign num = xin - v0;
  assign den = v1 - v0;
  assign cx = xv - xin;
  assign x1q = cbe_pkg::word_t'(W'({x1, 14'b0}));
  assign x2q = cbe_pkg::word_t'(W'({x2, 14'b0}));
  assign tfin = cbe_pkg::clamp_unit(tt);
  assign rd_addr = (state == S_LD1) ? cur + IW'(1) : cur;
  assign item_ready = (state == S_IDLE) && !pend;
  assign out_ch.valid = ovalid;
  assign out_ch.curve_param = ovalue;

  always_comb begin
    arith_state = 1'b0;
    areq.mul_go = 1'b0;
    areq.div_go = 1'b0;
    areq.a = coef_a;
    areq.b = tt;
    case (state)
      S_EX_A: begin
        arith_state = 1'b1;
        areq.mul_go = !issued;
      end
      S_EX_B, S_EX_C: begin
        arith_state = 1'b1;
        areq.mul_go = !issued;
        areq.a = xv;
      end
      S_ES_A: begin
        arith_state = 1'b1;
        areq.mul_go = !issued;
        areq.a = tt;
      end
      S_ES_B: begin
        arith_state = 1'b1;
        areq.mul_go = !issued;
        areq.b = t2;
      end
      S_ES_C: begin
        arith_state = 1'b1;
        areq.mul_go = !issued;
        areq.a = coef_b;
      end
      S_GUESS: begin
        arith_state = 1'b1;
        areq.mul_go = !issued;
        areq.a = frac;
        areq.b = hi - lo;
      end
      S_DDIV: begin
        arith_state = 1'b1;
        areq.div_go = !issued;
        areq.a = num;
        areq.b = den;
      end
      S_NT_DIV: begin
        arith_state = 1'b1;
        areq.div_go = !issued;
        areq.a = cx;
        areq.b = sv;
      end
      default: arith_state = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_FILL_WR) mem[fi] <= xv[TW-1:0];
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pend <= 1'b1;
      issued <= 1'b0;
      ovalid <= 1'b0;
      x1 <= '0;
      x2 <= cbe_pkg::ONE_Q16;
    end else begin
      if (ovalid && out_ch.ready && state != S_FINISH) ovalid <= 1'b0;
      if (arith_state) begin
        if (!issued) issued <= 1'b1;
        else if (arsp.done) issued <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pend) begin
            state <= S_FILL_INIT;
          end else if (item_valid) begin
            xin <= item_x;
            cur <= IW'(1);
            state <= S_SCAN_RD;
          end
        end
        S_FILL_INIT: begin
          if (!cfg_we) pend <= 1'b0;
          coef_a <= cbe_pkg::ONE_Q30 - ((x2q <<< 1) + x2q) + ((x1q <<< 1) + x1q);
          coef_b <= ((x2q <<< 1) + x2q) - ((x1q <<< 2) + (x1q <<< 1));
          coef_c <= (x1q <<< 1) + x1q;
          fi <= '0;
          tt <= tpos[0];
          ret <= S_FILL_WR;
          state <= S_EX_A;
        end
        S_FILL_WR: begin
          if (fi == IW'(SPLINE_POINTS - 1)) begin
            state <= S_IDLE;
          end else begin
            fi <= fi + IW'(1);
            tt <= tpos[fi + IW'(1)];
            state <= S_EX_A;
          end
        end
        S_EX_A: if (issued && arsp.done) begin
          xv <= arsp.res + coef_b;
          state <= S_EX_B;
        end
        S_EX_B: if (issued && arsp.done) begin
          xv <= arsp.res + coef_c;
          state <= S_EX_C;
        end
        S_EX_C: if (issued && arsp.done) begin
          xv <= arsp.res;
          state <= ret;
        end
        S_ES_A: if (issued && arsp.done) begin
          t2 <= arsp.res;
          state <= S_ES_B;
        end
        S_ES_B: if (issued && arsp.done) begin
          s1 <= arsp.res;
          state <= S_ES_C;
        end
        S_ES_C: if (issued && arsp.done) begin
          sv <= ((s1 <<< 1) + s1) + (arsp.res <<< 1) + coef_c;
          state <= ret;
        end
        S_SCAN_RD: state <= S_SCAN_CMP;
        S_SCAN_CMP: begin
          if (cur != IW'(SPLINE_POINTS - 1) && rdv <= xin) begin
            cur <= cur + IW'(1);
            state <= S_SCAN_RD;
          end else begin
            cur <= cur - IW'(1);
            state <= S_LD0;
          end
        end
        S_LD0: state <= S_LD1;
        S_LD1: begin
          v0 <= rdv;
          state <= S_LD2;
        end
        S_LD2: begin
          v1 <= rdv;
          lo <= tpos[cur];
          hi <= tpos[cur + IW'(1)];
          state <= S_DIST;
        end
        S_DIST: begin
          if (den <= 0 || num <= 0) begin
            frac <= '0;
            state <= S_GUESS;
          end else if (num >= den) begin
            frac <= cbe_pkg::ONE_Q30;
            state <= S_GUESS;
          end else begin
            state <= S_DDIV;
          end
        end
        S_DDIV: if (issued && arsp.done) begin
          frac <= arsp.res;
          state <= S_GUESS;
        end
        S_GUESS: if (issued && arsp.done) begin
          tt <= cbe_pkg::clamp_unit(lo + arsp.res);
          ret <= S_SLOPE0;
          state <= S_ES_A;
        end
        S_SLOPE0: begin
          nk <= '0;
          bi <= '0;
          if (sv >= cbe_pkg::MIN_SLOPE) state <= S_NT_CHK;
          else if (sv == 0) state <= S_FINISH;
          else state <= S_BS_MID;
        end
        S_NT_CHK: begin
          if (nk == NW'(NEWTON_STEPS)) begin
            state <= S_FINISH;
          end else begin
            ret <= S_NT_X;
            state <= S_ES_A;
          end
        end
        S_NT_X: begin
          if (sv == 0) begin
            state <= S_FINISH;
          end else begin
            ret <= S_NT_DIV;
            state <= S_EX_A;
          end
        end
        S_NT_DIV: if (issued && arsp.done) begin
          tt <= cbe_pkg::clamp_unit(tt - arsp.res);
          nk <= nk + NW'(1);
          state <= S_NT_CHK;
        end
        S_BS_MID: begin
          tt <= lo + ((hi - lo) >>> 1);
          ret <= S_BS_CHK;
          state <= S_EX_A;
        end
        S_BS_CHK: begin
          if (cx > 0) hi <= tt;
          else lo <= tt;
          if ((cx > cbe_pkg::PREC || cx < -cbe_pkg::PREC) && bi != BW'(BISECT_STEPS - 1)) begin
            bi <= bi + BW'(1);
            state <= S_BS_MID;
          end else begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!ovalid || out_ch.ready) begin
            ovalue <= cbe_pkg::DW'((tfin + cbe_pkg::word_t'(36'sd8192)) >>> 14);
            ovalid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (cfg_we) begin
        unique case (cbe_pkg::cfg_reg_t'(cfg_index))
          cbe_pkg::REG_X_FIRST: x1 <= cbe_pkg::sat_q16(cfg_data);
          cbe_pkg::REG_X_SECOND: x2 <= cbe_pkg::sat_q16(cfg_data);
          default: x1 <= x1;
        endcase
        pend <= 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

### rtl/cubic_bezier_easing_solver.sv
// Cubic Bezier easing solver top level: front queue, solve sequencer, shared arithmetic unit.
// Flow: the front queue, then a table scan, an optional divide for the first guess, and up to
// BISECT_STEPS bisection steps or up to NEWTON_STEPS Newton steps, all on the shared
// multiply and divide of the one arithmetic unit.
// Throughput: one item at a time in the solver; a two-entry queue takes items meanwhile.
// Reset and every register write refill the sample table once the solver is idle.
`default_nettype none
module cubic_bezier_easing_solver #(
  parameter int SPLINE_POINTS = 11,
  parameter int NEWTON_STEPS = 4,
  parameter int BISECT_STEPS = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  cbe_in_if.sink                        in_ch,
  cbe_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [cbe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cbe_pkg::DW-1:0]        cfg_data
);
  logic item_valid;
  logic item_ready;
  cbe_pkg::word_t item_x;
  cbe_pkg::arith_req_t areq;
  cbe_pkg::arith_rsp_t arsp;

  cbe_front u_front (
    .clk(clk), .rst(rst), .in_ch(in_ch),
    .item_valid(item_valid), .item_ready(item_ready), .item_x(item_x)
  );

  cbe_arith u_arith (.clk(clk), .rst(rst), .req(areq), .rsp(arsp));

  cbe_back #(
    .SPLINE_POINTS(SPLINE_POINTS), .NEWTON_STEPS(NEWTON_STEPS), .BISECT_STEPS(BISECT_STEPS)
  ) u_back (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .item_valid(item_valid), .item_ready(item_ready), .item_x(item_x),
    .out_ch(out_ch), .areq(areq), .arsp(arsp)
  );
endmodule
`default_nettype wire

### rtl/cbe_checker.sv
// Port-level assertions for the easing solver and their bind.
`default_nettype none
module cbe_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [16:0] out_data
);
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data <= cbe_pkg::ONE_Q16)
    else $error("result above 1.0");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result dropped or changed");
  a_rst_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result after reset");
  a_rst_in: assert property (@(posedge clk) rst |=> in_ready)
    else $error("queue not empty after reset");
endmodule

bind cubic_bezier_easing_solver cbe_checker u_chk (
  .clk(clk), .rst(rst), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.curve_param)
);
`default_nettype wire

### tb/cbe_checker.sv
// Scoreboard for the easing solver: watches both channels, predicts each curve parameter, compares.
`default_nettype none
module cbe_scoreboard (
  input  logic                          clk,
  input  logic                          rst,
  cbe_in_if                             in_ch,
  cbe_out_if                            out_ch,
  input  logic                          cfg_we,
  input  logic [cbe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cbe_pkg::DW-1:0]        cfg_data,
  output int                            fail_count,
  output int                            waiting
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POINTS = 11;
  localparam int NEWTON = 4;
  localparam int BISECT = 10;
  localparam longint UNIT = 64'sd1 << 30;
  localparam longint SLOPE_MIN = 64'sd1073742;
  localparam longint TOLERANCE = 64'sd107;

  logic [16:0] x_first;
  logic [16:0] x_second;
  longint      coef_a, coef_b, coef_c;
  longint      knots[POINTS];
  logic [16:0] expected_param[$];

  function automatic logic [16:0] limit_q16(logic [16:0] v);
    return (v > 17'd65536) ? 17'd65536 : v;
  endfunction

  function automatic longint fx_mul(longint p, longint q);
    longint unsigned mp, mq, r;
    mp = (p < 0) ? -p : p;
    mq = (q < 0) ? -q : q;
    r = (mp * mq + (64'd1 << 29)) >> 30;
    return ((p < 0) != (q < 0)) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint fx_div(longint n, longint d);
    longint unsigned mn, md, r;
    mn = (n < 0) ? -n : n;
    md = (d < 0) ? -d : d;
    r = (mn << 30) / md;
    return ((n < 0) != (d < 0)) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint to_unit(longint t);
    if (t < 0) return 0;
    if (t > UNIT) return UNIT;
    return t;
  endfunction

  function automatic longint curve_x(longint t);
    longint r;
    r = fx_mul(coef_a, t) + coef_b;
    r = fx_mul(r, t) + coef_c;
    return fx_mul(r, t);
  endfunction

  function automatic longint curve_slope(longint t);
    longint t2;
    t2 = fx_mul(t, t);
    return 3 * fx_mul(coef_a, t2) + 2 * fx_mul(coef_b, t) + coef_c;
  endfunction

  function automatic longint knot_t(int i);
    longint unsigned n;
    n = (longint'(i) << 30) + (POINTS - 1) / 2;
    return longint'(n / (POINTS - 1));
  endfunction

  function automatic void rebuild_knots();
    longint x1, x2;
    x1 = longint'(x_first) << 14;
    x2 = longint'(x_second) << 14;
    coef_a = UNIT - 3 * x2 + 3 * x1;
    coef_b = 3 * x2 - 6 * x1;
    coef_c = 3 * x1;
    for (int i = 0; i < POINTS; i++) knots[i] = curve_x(knot_t(i));
  endfunction

  function automatic longint solve_t(longint x);
    int     seg;
    longint lo, hi, num, den, frac, guess, slope, s, mid, cx;
    seg = 1;
    while (seg != POINTS - 1 && knots[seg] <= x) seg++;
    seg--;
    lo = knot_t(seg);
    hi = knot_t(seg + 1);
    num = x - knots[seg];
    den = knots[seg + 1] - knots[seg];
    if (den <= 0 || num <= 0) frac = 0;
    else if (num >= den) frac = UNIT;
    else frac = longint'((longint'(num) << 30) / den);
    guess = to_unit(lo + fx_mul(frac, hi - lo));
    slope = curve_slope(guess);
    if (slope >= SLOPE_MIN) begin
      for (int i = 0; i < NEWTON; i++) begin
        s = curve_slope(guess);
        if (s == 0) return guess;
        guess = to_unit(guess - fx_div(curve_x(guess) - x, s));
      end
      return guess;
    end
    if (slope == 0) return guess;
    for (int i = 0; i < BISECT; i++) begin
      mid = lo + (hi - lo) / 2;
      cx = curve_x(mid) - x;
      if (cx > 0) hi = mid;
      else lo = mid;
      if (cx <= TOLERANCE && cx >= -TOLERANCE) break;
    end
    return to_unit(mid);
  endfunction

  function automatic logic [16:0] predict_param(logic [16:0] progress);
    longint t;
    t = to_unit(solve_t(longint'(limit_q16(progress)) << 14));
    return 17'((t + 8192) >> 14);
  endfunction

  initial begin
    fail_count = 0;
    waiting = 0;
    x_first = '0;
    x_second = cbe_pkg::ONE_Q16;
    rebuild_knots();
  end

  always @(posedge clk) begin
    if (rst) begin
      x_first = '0;
      x_second = cbe_pkg::ONE_Q16;
      rebuild_knots();
      expected_param.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == cbe_pkg::REG_X_FIRST) x_first = limit_q16(cfg_data);
        else x_second = limit_q16(cfg_data);
        rebuild_knots();
      end
      if (in_ch.valid && in_ch.ready) expected_param.push_back(predict_param(in_ch.progress));
      if (out_ch.valid && out_ch.ready) begin
        if (expected_param.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected transfer: curve_param=%0d", out_ch.curve_param);
        end else if (out_ch.curve_param !== expected_param[0]) begin
          fail_count++;
          if (fail_count <= 10)
            $display("curve_param mismatch: expected %0d, got %0d",
                     expected_param[0], out_ch.curve_param);
          void'(expected_param.pop_front());
        end else begin
          void'(expected_param.pop_front());
        end
      end
    end
    waiting = expected_param.size();
  end
endmodule
`default_nettype wire

### tb/tb_cubic_bezier_easing_solver.sv
// Top of the easing solver testbench: clock, reset, stimulus, configuration phases and verdict.
`default_nettype none
module tb_cubic_bezier_easing_solver;
  timeunit 1ns;
  timeprecision 1ps;

  logic                          clk;
  logic                          rst;
  logic                          cfg_we;
  logic [cbe_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [cbe_pkg::DW-1:0]        cfg_data;
  int                            fail_count;
  int                            waiting;
  bit                            send_quiet;
  bit                            recv_quiet;
  bit                            hold_req;

  cbe_in_if  in_ch ();
  cbe_out_if out_ch ();

  cubic_bezier_easing_solver dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  cbe_scoreboard u_checker (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .waiting(waiting)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("** cubic_bezier_easing_solver: FAILED **");
    $finish;
  end

  task automatic send_progress(logic [16:0] x);
    int gap;
    gap = send_quiet ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.progress <= x;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic write_ctrl(logic [16:0] first, logic [16:0] second);
    in_ch.valid <= 1'b0;
    wait (waiting == 0);
    repeat (400) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= cbe_pkg::REG_X_FIRST;
    cfg_data <= first;
    @(negedge clk);
    cfg_index <= cbe_pkg::REG_X_SECOND;
    cfg_data <= second;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [16:0] pick_progress();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) return 17'($urandom_range(0, 65536));
    if (pick < 92) return 17'($urandom);
    return 17'($urandom_range(0, 10) * 6554 + $urandom_range(0, 8) - 4);
  endfunction

  // receiver: per-transfer stall, one long hold-off on request
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      gap = recv_quiet ? 0 : $urandom_range(0, 19);
      if (hold_req) begin
        hold_req = 1'b0;
        gap = 3000;
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      @(negedge clk);
    end
  end

  initial begin
    logic [16:0] edge_vals[20];
    logic [16:0] firsts[8];
    logic [16:0] seconds[8];
    edge_vals = '{17'd0, 17'd65536, 17'h1FFFF, 17'd65537, 17'd1, 17'd32768, 17'd65535,
                  17'd6554, 17'd6553, 17'd13107, 17'd19661, 17'd26214, 17'd39322,
                  17'd52429, 17'd58982, 17'd2, 17'h15555, 17'h0AAAA, 17'd100, 17'd65400};
    firsts  = '{17'd0, 17'd0, 17'd65536, 17'd65536, 17'h1FFFF, 17'd27525, 17'd0, 17'd0};
    seconds = '{17'd65536, 17'd0, 17'd65536, 17'd0, 17'd65537, 17'd65536, 17'd0, 17'd0};
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = cbe_pkg::REG_X_FIRST;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.progress = '0;
    send_quiet = 1'b0;
    recv_quiet = 1'b0;
    hold_req = 1'b0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    for (int p = 0; p < 10; p++) begin
      if (p > 0) begin
        if (p >= 6) write_ctrl(17'($urandom_range(0, 65536)), 17'($urandom_range(0, 65536)));
        else write_ctrl(firsts[p], seconds[p]);
      end
      if (p == 2) hold_req = 1'b1;
      foreach (edge_vals[i]) send_progress(edge_vals[i]);
      for (int k = 0; k < 165; k++) begin
        if (k % 40 == 0) begin
          send_quiet = ($urandom_range(0, 3) == 0);
          recv_quiet = ($urandom_range(0, 3) == 0);
        end
        send_progress(pick_progress());
      end
    end
    in_ch.valid <= 1'b0;
    wait (waiting == 0);
    repeat (400) @(negedge clk);
    if (fail_count == 0 && waiting == 0) $display("** cubic_bezier_easing_solver: PASSED **");
    else $display("** cubic_bezier_easing_solver: FAILED **");
    $finish;
  end
endmodule
`default_nettype wire

### sim.f
rtl/cbe_pkg.sv
rtl/cbe_in_if.sv
rtl/cbe_out_if.sv
rtl/cbe_front.sv
rtl/cbe_arith.sv
rtl/cbe_back.sv
rtl/cubic_bezier_easing_solver.sv
rtl/cbe_checker.sv
tb/cbe_checker.sv
tb/tb_cubic_bezier_easing_solver.sv
